### src/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types, constants, microcode table and seconds/microseconds helpers
// for the retry backoff schedule block.
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam logic [19:0] US_PER_SEC        = 20'd1000000;
    localparam logic [19:0] LOWER_LIMIT_RESET = 20'd300000;
    localparam logic [4:0]  MAX_RETRY         = 5'd29;
    localparam logic [15:0] SEC_SAT           = 16'hFFFF;
    localparam logic [19:0] USEC_SAT          = 20'd999999;

    // Width of the budget divider
    localparam int DIVIDEND_W = 36;
    localparam logic [5:0] DIV_LAST_CNT = 6'(DIVIDEND_W - 1);

    typedef struct packed {
        logic [4:0]  retry_count;
        logic [15:0] total_sec;
        logic [19:0] total_usec;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  slot;
        logic [15:0] interval_sec;
        logic [19:0] interval_usec;
        logic        last;
    } out_item_t;

    // Time value held as whole seconds plus microseconds below one million
    typedef struct packed {
        logic [17:0] s;
        logic [19:0] u;
    } tm_t;

    // Microcode
    typedef logic [2:0] pc_t;

    typedef enum logic [2:0] {
        OP_LOAD     = 3'd0,
        OP_DIV      = 3'd1,
        OP_EMIT     = 3'd4,
        OP_NOP      = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        COND_NONE = 2'd0,
        COND_IN   = 2'd1,
        COND_CNT  = 2'd2,
        COND_EMIT = 2'd3
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } cword_t;

    localparam pc_t P_WAIT     = 3'd0;
    localparam pc_t P_DIV      = 3'd1;
    localparam pc_t P_EMIT     = 3'd2;

    // Control program: load, divide budget into the base interval, emit slots
    function automatic cword_t ucode(input pc_t pc);
        cword_t cw;
        begin
            case (pc)
                P_WAIT:     cw = '{op: OP_LOAD,     cond: COND_IN,   target: P_WAIT};
                P_DIV:      cw = '{op: OP_DIV,      cond: COND_CNT,  target: P_DIV};
                P_EMIT:     cw = '{op: OP_EMIT,     cond: COND_EMIT, target: P_WAIT};
                default:    cw = '{op: OP_NOP,      cond: COND_CNT,  target: P_WAIT};
            endcase
            return cw;
        end
    endfunction

    function automatic logic tm_lt(input tm_t a, input tm_t b);
        begin
            return (a.s < b.s) || ((a.s == b.s) && (a.u < b.u));
        end
    endfunction

    function automatic tm_t tm_add(input tm_t a, input tm_t b);
        logic [20:0] usum;
        tm_t         r;
        begin
            usum = {1'b0, a.u} + {1'b0, b.u};
            if (usum >= {1'b0, US_PER_SEC})
            begin
                r.u = 20'(usum - {1'b0, US_PER_SEC});
                r.s = 18'(a.s + b.s + 18'd1);
            end
            else
            begin
                r.u = usum[19:0];
                r.s = 18'(a.s + b.s);
            end
            return r;
        end
    endfunction

    // Double a and add one microsecond when b is set
    function automatic tm_t tm_dbl(input tm_t a, input logic b);
        logic [20:0] usum;
        tm_t         r;
        begin
            usum = {a.u, b};
            if (usum >= {1'b0, US_PER_SEC})
            begin
                r.u = 20'(usum - {1'b0, US_PER_SEC});
                r.s = {a.s[16:0], 1'b1};
            end
            else
            begin
                r.u = usum[19:0];
                r.s = {a.s[16:0], 1'b0};
            end
            return r;
        end
    endfunction

    // Valid for a not below b
    function automatic tm_t tm_sub(input tm_t a, input tm_t b);
        logic [20:0] udif;
        tm_t         r;
        begin
            udif = {1'b0, a.u} - {1'b0, b.u};
            if (udif[20])
            begin
                r.u = 20'(udif + {1'b0, US_PER_SEC});
                r.s = 18'(a.s - b.s - 18'd1);
            end
            else
            begin
                r.u = udif[19:0];
                r.s = 18'(a.s - b.s);
            end
            return r;
        end
    endfunction

endpackage

### src/retry_backoff_schedule.sv
// ----------------------------------------------------------------------------
// retry_backoff_schedule
// Splits a time budget into retry_count+1 doubling timeout intervals.
// ----------------------------------------------------------------------------
// One input item yields retry_count+1 result transfers (retry_count saturates
// at 29). An item first loads, then the budget in microseconds is divided
// by 2^(slots)-1 on a one-bit restoring divider that builds the base
// interval directly in seconds and microseconds as quotient bits arrive,
// then results leave one per cycle while the output register is not held.
// Control is a three-word microcode program with a step counter; in_ready
// is high only at the program's wait step. The result register lets the
// next item load while the final result is still pending. The user is to
// write lower_limit_us through cfg_we/cfg_wdata only while the block is
// idle; the block itself does not enforce this. The limit is sampled when
// an item is taken.
// ----------------------------------------------------------------------------
module retry_backoff_schedule
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rbs_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rbs_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic [19:0]         cfg_wdata
);

    // Sequencer
    rbs_pkg::pc_t    pc_reg, pc_next;
    rbs_pkg::cword_t cw;
    logic [5:0]      cnt_reg, cnt_next;

    // Divider
    logic [35:0] quo_reg, quo_next;
    logic [29:0] rem_reg, rem_next;
    logic [29:0] dvs_reg, dvs_next;
    logic [30:0] rem_sh;
    logic        div_ge;

    // Schedule datapath
    logic [19:0]        lim_cfg_reg;
    logic [4:0]         slots_reg, slots_next;
    logic [4:0]         slot_reg, slot_next;
    rbs_pkg::tm_t       bud_reg, bud_next;
    rbs_pkg::tm_t       used_reg, used_next;
    rbs_pkg::tm_t       step_reg, step_next;
    rbs_pkg::tm_t       lim_reg, lim_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    rbs_pkg::out_item_t out_data_reg, out_data_next;

    // Load-time values
    logic [4:0]   n_sat;
    logic [35:0]  bud_bin;
    logic [29:0]  dvs_load;
    rbs_pkg::tm_t bud_tm;
    rbs_pkg::tm_t lim_tm;

    // Emit-time values
    logic         out_busy;
    logic         emit_fire;
    logic         is_last;
    logic         active;
    logic         below;
    logic         rem_gt;
    rbs_pkg::tm_t left_tm;
    rbs_pkg::tm_t iv;

    assign cw        = rbs_pkg::ucode(pc_reg);
    assign in_ready  = (pc_reg == rbs_pkg::P_WAIT);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_busy  = out_valid_reg && !out_ready;
    assign emit_fire = (cw.op == rbs_pkg::OP_EMIT) && !out_busy;
    assign is_last   = (slot_reg == slots_reg);

    // Decode the incoming item
    always_comb
    begin
        n_sat    = (in_data.retry_count > rbs_pkg::MAX_RETRY) ? rbs_pkg::MAX_RETRY
                                                              : in_data.retry_count;
        bud_bin  = 36'(in_data.total_sec) * 36'(rbs_pkg::US_PER_SEC)
                 + 36'(in_data.total_usec);
        dvs_load = 30'((31'd1 << (5'(n_sat + 5'd1))) - 31'd1);
        if (in_data.total_usec >= rbs_pkg::US_PER_SEC)
        begin
            bud_tm.s = 18'(in_data.total_sec) + 18'd1;
            bud_tm.u = 20'(in_data.total_usec - rbs_pkg::US_PER_SEC);
        end
        else
        begin
            bud_tm.s = 18'(in_data.total_sec);
            bud_tm.u = in_data.total_usec;
        end
        if (lim_cfg_reg >= rbs_pkg::US_PER_SEC)
        begin
            lim_tm.s = 18'd1;
            lim_tm.u = 20'(lim_cfg_reg - rbs_pkg::US_PER_SEC);
        end
        else
        begin
            lim_tm.s = 18'd0;
            lim_tm.u = lim_cfg_reg;
        end
    end

    // One restoring division step
    assign rem_sh = {rem_reg, quo_reg[35]};
    assign div_ge = (rem_sh >= {1'b0, dvs_reg});

    // Interval selection for the current slot
    always_comb
    begin
        active  = rbs_pkg::tm_lt(used_reg, bud_reg);
        left_tm = rbs_pkg::tm_sub(bud_reg, used_reg);
        below   = rbs_pkg::tm_lt(step_reg, lim_reg);
        rem_gt  = rbs_pkg::tm_lt(step_reg, left_tm);
        if (!active)
            iv = '0;
        else if (below)
            iv = lim_reg;
        else if (rem_gt)
            iv = step_reg;
        else
            iv = left_tm;
    end

    // Advance the step counter
    always_comb
    begin
        pc_next = 3'(pc_reg + 3'd1);
        case (cw.cond)
            rbs_pkg::COND_NONE: pc_next = 3'(pc_reg + 3'd1);
            rbs_pkg::COND_IN:
            begin
                if (!in_valid)
                    pc_next = pc_reg;
            end
            rbs_pkg::COND_CNT:
            begin
                if (cnt_reg != 6'd0)
                    pc_next = cw.target;
            end
            rbs_pkg::COND_EMIT:
            begin
                if (out_busy || !is_last)
                    pc_next = pc_reg;
                else
                    pc_next = cw.target;
            end
            default: pc_next = rbs_pkg::P_WAIT;
        endcase
    end

    // Datapath driven by the control word
    always_comb
    begin
        cnt_next       = cnt_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        slots_next     = slots_reg;
        slot_next      = slot_reg;
        bud_next       = bud_reg;
        used_next      = used_reg;
        step_next      = step_reg;
        lim_next       = lim_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (cw.op)
            rbs_pkg::OP_LOAD:
            begin
                if (in_valid)
                begin
                    cnt_next   = rbs_pkg::DIV_LAST_CNT;
                    quo_next   = bud_bin;
                    rem_next   = '0;
                    dvs_next   = dvs_load;
                    slots_next = 5'(n_sat + 5'd1);
                    slot_next  = 5'd1;
                    bud_next   = bud_tm;
                    used_next  = '0;
                    step_next  = '0;
                    lim_next   = lim_tm;
                end
            end
            rbs_pkg::OP_DIV:
            begin
                cnt_next  = 6'(cnt_reg - 6'd1);
                rem_next  = div_ge ? 30'(rem_sh - {1'b0, dvs_reg}) : rem_sh[29:0];
                quo_next  = {quo_reg[34:0], div_ge};
                // Shift the quotient bit into the base interval
                step_next = rbs_pkg::tm_dbl(step_reg, div_ge);
            end
            rbs_pkg::OP_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next      = 1'b1;
                    out_data_next.slot  = slot_reg;
                    out_data_next.last  = is_last;
                    if (iv.s[17:16] != 2'd0)
                    begin
                        out_data_next.interval_sec  = rbs_pkg::SEC_SAT;
                        out_data_next.interval_usec = rbs_pkg::USEC_SAT;
                    end
                    else
                    begin
                        out_data_next.interval_sec  = iv.s[15:0];
                        out_data_next.interval_usec = iv.u;
                    end
                    slot_next = 5'(slot_reg + 5'd1);
                    if (active)
                    begin
                        step_next = rbs_pkg::tm_add(step_reg, step_reg);
                        if (below)
                            used_next = rbs_pkg::tm_add(used_reg, lim_reg);
                        else if (rem_gt)
                            used_next = rbs_pkg::tm_add(used_reg, step_reg);
                        else
                            used_next = bud_reg;
                    end
                end
            end
            default: cnt_next = cnt_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= rbs_pkg::P_WAIT;
            out_valid_reg <= 1'b0;
            lim_cfg_reg   <= rbs_pkg::LOWER_LIMIT_RESET;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                lim_cfg_reg <= cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        slots_reg    <= slots_next;
        slot_reg     <= slot_next;
        bud_reg      <= bud_next;
        used_reg     <= used_next;
        step_reg     <= step_next;
        lim_reg      <= lim_next;
        out_data_reg <= out_data_next;
    end

    // Checks
    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == rbs_pkg::P_DIV) |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == rbs_pkg::P_EMIT) |-> (slot_reg != 5'd0 && slot_reg <= slots_reg))
        else $error("slot outside schedule");

    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && is_last) |=> (pc_reg == rbs_pkg::P_WAIT && out_valid && out_data.last))
        else $error("final interval did not end the program");

endmodule

### test/tb_retry_backoff_schedule.sv
// ----------------------------------------------------------------------------
// tb_retry_backoff_schedule
// Self-checking bench for the retry backoff schedule block. Requests go in
// through a queue-fed driver, and each accepted request is expanded into its
// expected run of timeout intervals by a local schedule predictor. A monitor
// compares every result transfer against the oldest expected interval. The
// lower limit is reprogrammed between phases, and both handshake sides stall
// at random rates set per phase, with no stalls in the last two phases.
// ----------------------------------------------------------------------------
module tb_retry_backoff_schedule;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned DRAIN_CYCLES = 150;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_ITEMS  = 60;
    localparam int unsigned BATCH_ITEMS  = 15;
    localparam logic [19:0] LIMIT_MAX    = 20'hFFFFF;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    rbs_pkg::in_item_t  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    rbs_pkg::out_item_t out_data;
    logic               cfg_we    = 1'b0;
    logic [19:0]        cfg_wdata = '0;

    // Local copy of the lower limit register
    logic [19:0] floor_us      = rbs_pkg::LOWER_LIMIT_RESET;
    int unsigned send_idle_pct = 38;
    int unsigned recv_idle_pct = 49;
    int unsigned mismatches    = 0;
    int unsigned cycles        = 0;

    rbs_pkg::in_item_t  request_q[$];
    rbs_pkg::out_item_t expected_intervals[$];

    retry_backoff_schedule dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Expand one request into its doubling intervals and queue them
    function automatic void predict_schedule(input rbs_pkg::in_item_t req);
        logic [63:0]        budget;
        logic [63:0]        step;
        logic [63:0]        spent;
        logic [63:0]        iv;
        logic [63:0]        secs;
        logic [63:0]        usecs;
        int unsigned        slots;
        int unsigned        i;
        rbs_pkg::out_item_t r;
        begin
            slots  = (req.retry_count > rbs_pkg::MAX_RETRY) ? rbs_pkg::MAX_RETRY + 1
                                                            : req.retry_count + 1;
            budget = 64'(req.total_sec) * 64'(rbs_pkg::US_PER_SEC) + 64'(req.total_usec);
            step   = budget / ((64'd1 << slots) - 64'd1);
            spent  = '0;
            for (i = 1; i <= slots; i++)
            begin
                iv = '0;
                // Raise short intervals to the floor, cut the one that runs out
                if (budget > spent)
                begin
                    if (step < 64'(floor_us))
                    begin
                        iv    = 64'(floor_us);
                        spent = spent + 64'(floor_us);
                    end
                    else if (budget - spent > step)
                    begin
                        iv    = step;
                        spent = spent + step;
                    end
                    else
                    begin
                        iv    = budget - spent;
                        spent = budget;
                    end
                    step = step << 1;
                end
                secs  = iv / 64'(rbs_pkg::US_PER_SEC);
                usecs = iv % 64'(rbs_pkg::US_PER_SEC);
                if (secs > 64'(rbs_pkg::SEC_SAT))
                begin
                    secs  = 64'(rbs_pkg::SEC_SAT);
                    usecs = 64'(rbs_pkg::USEC_SAT);
                end
                r.slot          = 5'(i);
                r.interval_sec  = secs[15:0];
                r.interval_usec = usecs[19:0];
                r.last          = (i == slots);
                expected_intervals.push_back(r);
            end
        end
    endfunction

    function automatic void queue_request(input logic [4:0] retries, input logic [15:0] secs,
                                          input logic [19:0] usecs);
        rbs_pkg::in_item_t req;
        begin
            req.retry_count = retries;
            req.total_sec   = secs;
            req.total_usec  = usecs;
            request_q.push_back(req);
        end
    endfunction

    // Mostly sane retry counts and budgets near the floor, with some wide values
    function automatic rbs_pkg::in_item_t random_request();
        rbs_pkg::in_item_t req;
        int unsigned       pick;
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                req.retry_count = '0;
            else if (pick == 1)
                req.retry_count = 5'($urandom_range(30, 31));
            else
                req.retry_count = 5'($urandom_range(1, 29));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                req.total_sec = '0;
            else if (pick <= 5)
                req.total_sec = 16'($urandom_range(0, 40));
            else if (pick <= 7)
                req.total_sec = 16'($urandom_range(0, 2000));
            else
                req.total_sec = 16'($urandom);
            pick = $urandom_range(0, 19);
            if (pick == 0)
                req.total_usec = '0;
            else if (pick <= 2)
                req.total_usec = 20'($urandom_range(1000000, 20'hFFFFF));
            else
                req.total_usec = 20'($urandom_range(0, 999999));
            return req;
        end
    endfunction

    // Hold until no request is pending and every interval has been seen
    task automatic wait_idle();
        while (request_q.size() != 0 || in_valid || expected_intervals.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_floor(input logic [19:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        floor_us   = value;
        @(negedge clk);
    endtask

    // Driver: predict on each input transfer, then offer the next request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_schedule(in_data);
            if (!in_valid || in_ready)
            begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= request_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random and check each output transfer
    always @(posedge clk)
    begin : monitor
        rbs_pkg::out_item_t want;
        if (rst_n)
        begin
            out_ready <= (recv_idle_pct == 0) || ($urandom_range(0, 99) >= recv_idle_pct);
            if (out_valid && out_ready)
            begin
                if (expected_intervals.size() == 0)
                begin
                    mismatches++;
                    $display({"%0t: expected no interval,",
                              " got slot=%0d sec=%0d usec=%0d last=%0b"},
                             $time, out_data.slot, out_data.interval_sec,
                             out_data.interval_usec, out_data.last);
                end
                else
                begin
                    want = expected_intervals.pop_front();
                    if (out_data !== want)
                    begin
                        mismatches++;
                        $display({"%0t: expected slot=%0d sec=%0d usec=%0d last=%0b,",
                                  " got slot=%0d sec=%0d usec=%0d last=%0b"},
                                 $time, want.slot, want.interval_sec,
                                 want.interval_usec, want.last, out_data.slot,
                                 out_data.interval_sec, out_data.interval_usec,
                                 out_data.last);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_retry_backoff_schedule: errors");
            $finish;
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned b;
        int unsigned k;
        logic [19:0] phase_floor;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Edge cases under the reset floor
        queue_request(5'd0,  16'd10,    20'd0);        // zero retries, whole budget
        queue_request(5'd0,  16'd0,     20'd100);      // zero retries, raised to floor
        queue_request(5'd31, 16'd100,   20'd0);        // retry count saturates
        queue_request(5'd30, 16'd1000,  20'd5);
        queue_request(5'd29, 16'hFFFF,  20'd999999);
        queue_request(5'd1,  16'd0,     20'd0);        // empty budget
        queue_request(5'd29, 16'd0,     20'd0);
        queue_request(5'd3,  16'd5,     20'hFFFFF);    // microseconds past a second
        queue_request(5'd0,  16'hFFFF,  20'hFFFFF);    // interval too long, saturate
        queue_request(5'd0,  16'hFFFF,  20'd999999);
        queue_request(5'd1,  16'hFFFF,  20'd0);
        queue_request(5'd5,  16'd3,     20'd0);
        queue_request(5'd2,  16'd7,     20'd0);
        queue_request(5'd4,  16'd1,     20'd500000);
        queue_request(5'd10, 16'd60,    20'd123456);
        queue_request(5'd1,  16'd0,     20'd300000);
        wait_idle();

        // Floor above one second
        write_floor(LIMIT_MAX);
        queue_request(5'd3,  16'd2,     20'd0);
        queue_request(5'd0,  16'd0,     20'd1);
        queue_request(5'd2,  16'd20,    20'd0);
        wait_idle();

        // No floor at all
        write_floor('0);
        queue_request(5'd29, 16'd0,     20'd1);
        queue_request(5'd1,  16'd0,     20'd0);
        queue_request(5'd3,  16'd15,    20'd0);
        wait_idle();

        // Random phases: new floor and stall pattern per phase
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       phase_floor = rbs_pkg::LOWER_LIMIT_RESET;
                2:       phase_floor = '0;
                3:       phase_floor = rbs_pkg::USEC_SAT;
                5:       phase_floor = LIMIT_MAX;
                default: phase_floor = 20'($urandom_range(0, 20'hFFFFF));
            endcase
            if (phase < 2)
            begin
                send_idle_pct = 38;
                recv_idle_pct = 49;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 38;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_floor(phase_floor);
            for (b = 0; b < PHASE_ITEMS / BATCH_ITEMS; b++)
            begin
                for (k = 0; k < BATCH_ITEMS; k++)
                    request_q.push_back(random_request());
                while (request_q.size() != 0)
                    @(negedge clk);
                // Now and then let the block drain completely
                if ($urandom_range(0, 3) == 0)
                    wait_idle();
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("tb_retry_backoff_schedule: clean");
        else
            $display("tb_retry_backoff_schedule: errors");
        $finish;
    end

endmodule
